>>> sv/llas_pkg.sv
`default_nettype none

package llas_pkg;

   // Field and register widths
   localparam int DIM_W      = 7;
   localparam int TOT_W      = 2 * DIM_W;
   localparam int IDX_W      = 12;
   localparam int CNT_W      = 13;
   localparam int MASK_W     = 9;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 9;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SURVIVE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 8'd3;

   // Register reset values
   localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'h03f;
   localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'h008;
   localparam logic [DIM_W-1:0]  DIM_RESET     = 7'd64;
   localparam logic [DIM_W-1:0]  DIM_MIN       = 7'd3;

   // Item modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_STEP  = 2'd2;

   typedef struct packed {
      logic [1:0]       mode;
      logic [IDX_W-1:0] cell_index;
      logic             cell_value;
   } req_type;

   typedef struct packed {
      logic             read_alive;
      logic [CNT_W-1:0] changed_count;
   } rsp_type;

   // Rule masks and clamped grid size
   typedef struct packed {
      logic [MASK_W-1:0] survive_mask;
      logic [MASK_W-1:0] birth_mask;
      logic [DIM_W-1:0]  cols;
      logic [DIM_W-1:0]  rows;
   } cfg_type;

endpackage

`default_nettype wire

>>> sv/llas_rsp_reg.sv
`default_nettype none

module llas_rsp_reg import llas_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire rsp_type push_data,
   output logic         push_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    full_ff, full_in;
   rsp_type data_ff, data_in;

   // One-entry output register: refills in the cycle the held item leaves
   assign push_ready = !full_ff || !rsp_stall;

   always_comb begin
      full_in = full_ff;
      data_in = data_ff;
      if (push_valid && push_ready) begin
         full_in = 1'b1;
         data_in = push_data;
      end else if (full_ff && !rsp_stall) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = full_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

>>> sv/llas_engine.sv
`default_nettype none

module llas_engine import llas_pkg::*; #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire cfg_type cfg,
   output logic         push_valid,
   input  wire logic    push_ready,
   output rsp_type      push_data
);

   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int PW    = $clog2(CELLS + 1);

   typedef enum logic [8:0] {
      ST_CLEAR     = 9'b000000001,
      ST_IDLE      = 9'b000000010,
      ST_WRITE     = 9'b000000100,
      ST_READ      = 9'b000001000,
      ST_READ_DATA = 9'b000010000,
      ST_FETCH     = 9'b000100000,
      ST_DRAIN     = 9'b001000000,
      ST_COPY      = 9'b010000000,
      ST_DONE      = 9'b100000000
   } state_type;

   // Grid storage and next-generation scratch
   logic cell_mem [CELLS];
   logic next_mem [CELLS];

   state_type         state_ff, state_in;
   req_type           item_ff, item_in;
   rsp_type           res_ff, res_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [PW-1:0]     base_ff, base_in;
   logic [PW-1:0]     up_ff, up_in;
   logic [PW-1:0]     dn_ff, dn_in;
   logic [DIM_W-1:0]  fcol_ff, fcol_in;
   logic [DIM_W:0]    fnum_ff, fnum_in;
   logic [1:0]        ph_ff, ph_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [1:0]        rd_ph_ff, rd_ph_in;
   logic [1:0]        colbuf_ff, colbuf_in;
   logic [2:0]        win_l_ff, win_l_in;
   logic [2:0]        win_c_ff, win_c_in;
   logic [2:0]        win_r_ff, win_r_in;
   logic [1:0]        win_cnt_ff, win_cnt_in;
   logic              eval_vld_ff, eval_vld_in;
   logic [DIM_W-1:0]  ecol_ff, ecol_in;
   logic [CNT_W-1:0]  changed_ff, changed_in;
   logic [PW-1:0]     cp_k_ff, cp_k_in;
   logic              cp_vld_ff, cp_vld_in;
   logic [AW-1:0]     cp_addr_ff, cp_addr_in;
   logic              cell_q_ff;
   logic              next_q_ff;

   logic              cell_we;
   logic [AW-1:0]     cell_waddr;
   logic              cell_wdata;
   logic [AW-1:0]     cell_raddr;
   logic              next_we;
   logic [AW-1:0]     next_waddr;
   logic              next_wdata;
   logic [AW-1:0]     next_raddr;

   logic [TOT_W-1:0]  total_wide;
   logic [PW-1:0]     total_p;
   logic [PW-1:0]     cols_p;
   logic              idx_ok;
   logic [AW-1:0]     idx_addr;
   logic [PW-1:0]     sel_base;
   logic [PW-1:0]     fetch_pos;
   logic [DIM_W-1:0]  last_col;
   logic [3:0]        nbr_count;
   logic              nxt_alive;

   // Grid size and index range
   assign total_wide = TOT_W'(cfg.cols) * TOT_W'(cfg.rows);
   assign total_p    = PW'(total_wide);
   assign cols_p     = PW'(cfg.cols);
   assign idx_ok     = TOT_W'(item_ff.cell_index) < total_wide;
   assign idx_addr   = AW'(item_ff.cell_index);
   assign last_col   = cfg.cols - DIM_W'(1);

   // Fetch address: one of the three row bases plus the column
   always_comb begin
      case (ph_ff)
         2'd0:    sel_base = up_ff;
         2'd1:    sel_base = base_ff;
         default: sel_base = dn_ff;
      endcase
   end
   assign fetch_pos = sel_base + PW'(fcol_ff);

   // Neighbor count over the 3x3 window, centre excluded
   assign nbr_count = 4'(win_l_ff[0]) + 4'(win_l_ff[1]) + 4'(win_l_ff[2]) +
                      4'(win_c_ff[0]) + 4'(win_c_ff[2]) +
                      4'(win_r_ff[0]) + 4'(win_r_ff[1]) + 4'(win_r_ff[2]);

   always_comb begin
      if (win_c_ff[1]) begin
         nxt_alive = cfg.survive_mask[nbr_count];
      end else begin
         nxt_alive = (nbr_count != 4'd0) && cfg.birth_mask[nbr_count];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      res_in      = res_ff;
      clr_in      = clr_ff;
      row_in      = row_ff;
      base_in     = base_ff;
      up_in       = up_ff;
      dn_in       = dn_ff;
      fcol_in     = fcol_ff;
      fnum_in     = fnum_ff;
      ph_in       = ph_ff;
      colbuf_in   = colbuf_ff;
      win_l_in    = win_l_ff;
      win_c_in    = win_c_ff;
      win_r_in    = win_r_ff;
      win_cnt_in  = win_cnt_ff;
      ecol_in     = ecol_ff;
      changed_in  = changed_ff;
      cp_k_in     = cp_k_ff;
      cp_addr_in  = cp_addr_ff;
      rd_vld_in   = (state_ff == ST_FETCH);
      rd_ph_in    = ph_ff;
      eval_vld_in = 1'b0;
      cp_vld_in   = 1'b0;

      cell_we     = 1'b0;
      cell_waddr  = idx_addr;
      cell_wdata  = item_ff.cell_value;
      cell_raddr  = AW'(fetch_pos);
      next_we     = 1'b0;
      next_waddr  = AW'(base_ff + PW'(ecol_ff));
      next_wdata  = nxt_alive;
      next_raddr  = AW'(cp_k_ff);
      push_valid  = 1'b0;
      push_data   = res_ff;

      // Read return: collect up/mid, then shift a full column into the window
      if (rd_vld_ff) begin
         case (rd_ph_ff)
            2'd0: colbuf_in[0] = cell_q_ff;
            2'd1: colbuf_in[1] = cell_q_ff;
            default: begin
               win_l_in = win_c_ff;
               win_c_in = win_r_ff;
               win_r_in = {cell_q_ff, colbuf_ff[1], colbuf_ff[0]};
               if (win_cnt_ff == 2'd2) begin
                  eval_vld_in = 1'b1;
               end else begin
                  win_cnt_in = win_cnt_ff + 2'd1;
               end
            end
         endcase
      end

      // Evaluate the centre cell and store its next state
      if (eval_vld_ff) begin
         next_we = 1'b1;
         ecol_in = ecol_ff + DIM_W'(1);
         if (nxt_alive != win_c_ff[1]) begin
            changed_in = changed_ff + CNT_W'(1);
         end
      end

      // Copy write-back of the new generation
      if (cp_vld_ff) begin
         cell_we    = 1'b1;
         cell_waddr = cp_addr_ff;
         cell_wdata = next_q_ff;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = clr_ff;
            cell_wdata = 1'b0;
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               unique case (req_data.mode)
                  MODE_WRITE: state_in = ST_WRITE;
                  MODE_READ:  state_in = ST_READ;
                  MODE_STEP: begin
                     row_in     = '0;
                     base_in    = '0;
                     up_in      = total_p - cols_p;
                     dn_in      = cols_p;
                     fcol_in    = last_col;
                     fnum_in    = '0;
                     ph_in      = 2'd0;
                     win_cnt_in = 2'd0;
                     ecol_in    = '0;
                     changed_in = '0;
                     state_in   = ST_FETCH;
                  end
                  default: begin
                     res_in   = '0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            cell_we  = idx_ok;
            res_in   = '0;
            state_in = ST_DONE;
         end
         ST_READ: begin
            cell_raddr = idx_addr;
            state_in   = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            res_in.read_alive    = idx_ok & cell_q_ff;
            res_in.changed_count = '0;
            state_in             = ST_DONE;
         end
         ST_FETCH: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd2) begin
               ph_in   = 2'd0;
               fcol_in = (fcol_ff == last_col) ? '0 : fcol_ff + DIM_W'(1);
               fnum_in = fnum_ff + (DIM_W+1)'(1);
               if (fnum_ff == (DIM_W+1)'(cfg.cols) + (DIM_W+1)'(1)) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // Wait for the last column to land and be evaluated
            if (!rd_vld_ff && !eval_vld_ff) begin
               if (row_ff == cfg.rows - DIM_W'(1)) begin
                  cp_k_in  = '0;
                  state_in = ST_COPY;
               end else begin
                  row_in     = row_ff + DIM_W'(1);
                  base_in    = base_ff + cols_p;
                  up_in      = base_ff;
                  dn_in      = (row_ff + DIM_W'(1) == cfg.rows - DIM_W'(1)) ?
                               '0 : dn_ff + cols_p;
                  fcol_in    = last_col;
                  fnum_in    = '0;
                  ph_in      = 2'd0;
                  win_cnt_in = 2'd0;
                  ecol_in    = '0;
                  state_in   = ST_FETCH;
               end
            end
         end
         ST_COPY: begin
            if (cp_k_ff < total_p) begin
               cp_vld_in  = 1'b1;
               cp_addr_in = AW'(cp_k_ff);
               cp_k_in    = cp_k_ff + PW'(1);
            end else if (!cp_vld_ff) begin
               res_in.read_alive    = 1'b0;
               res_in.changed_count = changed_ff;
               state_in             = ST_DONE;
            end
         end
         ST_DONE: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         eval_vld_ff <= 1'b0;
         cp_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         rd_vld_ff   <= rd_vld_in;
         eval_vld_ff <= eval_vld_in;
         cp_vld_ff   <= cp_vld_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      res_ff     <= res_in;
      row_ff     <= row_in;
      base_ff    <= base_in;
      up_ff      <= up_in;
      dn_ff      <= dn_in;
      fcol_ff    <= fcol_in;
      fnum_ff    <= fnum_in;
      ph_ff      <= ph_in;
      rd_ph_ff   <= rd_ph_in;
      colbuf_ff  <= colbuf_in;
      win_l_ff   <= win_l_in;
      win_c_ff   <= win_c_in;
      win_r_ff   <= win_r_in;
      win_cnt_ff <= win_cnt_in;
      ecol_ff    <= ecol_in;
      changed_ff <= changed_in;
      cp_k_ff    <= cp_k_in;
      cp_addr_ff <= cp_addr_in;
   end

   // Cell memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_q_ff <= cell_mem[cell_raddr];
   end

   // Next-generation memory
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      next_q_ff <= next_mem[next_raddr];
   end

   // Fetches stay inside the grid in use
   a_fetch_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (fetch_pos < total_p))
      else $error("cell fetch outside grid");

   // Evaluated column never passes the row end
   a_eval_col: assert property (@(posedge clock) disable iff (reset)
      eval_vld_ff |-> (ecol_ff < cfg.cols))
      else $error("evaluated column out of range");

   // No evaluation left behind when the row sequencer moves on
   a_eval_phase: assert property (@(posedge clock) disable iff (reset)
      eval_vld_ff |-> (state_ff == ST_FETCH || state_ff == ST_DRAIN))
      else $error("evaluation outside step scan");

   // Copy starts only once the scan pipeline has emptied
   a_copy_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (!rd_vld_ff && !eval_vld_ff))
      else $error("copy overlaps scan pipeline");

   // Copy write-back stays inside the grid in use
   a_copy_in_grid: assert property (@(posedge clock) disable iff (reset)
      cp_vld_ff |-> (PW'(cp_addr_ff) < total_p))
      else $error("copy write outside grid");

endmodule

`default_nettype wire

>>> sv/life_like_automaton_step.sv
// A write item writes one cell; a read item reads one cell through the registered read port.
// A step item scans the grid row by row with three cell memory reads per column
// through the single read port, then runs a copy-back pass over the new generation.
// One item is in work at a time; the next is accepted once the result sits in the
// output register. After reset a clearing pass over all MAX_COLS*MAX_ROWS cells holds
// req_stall high; configuration registers return to their defaults at once.
`default_nettype none

module life_like_automaton_step import llas_pkg::*; #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_HI = (MAX_COLS > 127) ? 127 : MAX_COLS;
   localparam int ROW_HI = (MAX_ROWS > 127) ? 127 : MAX_ROWS;

   logic [MASK_W-1:0] survive_ff, survive_in;
   logic [MASK_W-1:0] birth_ff, birth_in;
   logic [DIM_W-1:0]  cols_ff, cols_in;
   logic [DIM_W-1:0]  rows_ff, rows_in;
   cfg_type           cfg;
   logic              push_valid;
   logic              push_ready;
   rsp_type           push_data;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v < DIM_MIN) begin
         r = DIM_MIN;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Register write decode
   always_comb begin
      survive_in = survive_ff;
      birth_in   = birth_ff;
      cols_in    = cols_ff;
      rows_in    = rows_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SURVIVE: survive_in = csr_wdata;
            CSR_BIRTH:   birth_in   = csr_wdata;
            CSR_COLS:    cols_in    = csr_wdata[DIM_W-1:0];
            CSR_ROWS:    rows_in    = csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         survive_ff <= SURVIVE_RESET;
         birth_ff   <= BIRTH_RESET;
         cols_ff    <= DIM_RESET;
         rows_ff    <= DIM_RESET;
      end else begin
         survive_ff <= survive_in;
         birth_ff   <= birth_in;
         cols_ff    <= cols_in;
         rows_ff    <= rows_in;
      end
   end

   // Rule masks and clamped torus size
   always_comb begin
      cfg.survive_mask = survive_ff;
      cfg.birth_mask   = birth_ff;
      cfg.cols         = clamp_dim(cols_ff, DIM_W'(COL_HI));
      cfg.rows         = clamp_dim(rows_ff, DIM_W'(ROW_HI));
   end

   llas_engine #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   llas_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
